// File: hw/rtl/app_pp_pkg.sv
package app_pp_pkg;

  localparam int ByteW     = 8;
  localparam int EventW    = 3;
  localparam int ValueW    = 64;
  localparam int LenW      = 16;
  localparam int ParamCntW = 4;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 8;

  typedef enum logic [EventW-1:0] {
    EV_PAYLOAD  = 3'd0,
    EV_NAME     = 3'd1,
    EV_LENGTH   = 3'd2,
    EV_DONE     = 3'd3,
    EV_BAD_CTRL = 3'd4,
    EV_BAD_TYPE = 3'd5
  } event_t;

  localparam logic [CfgIdxW-1:0] CFG_DATA_CODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_START_CODE = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_END_CODE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SIZE_TYPE  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_NAME_TYPE  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_PARAM_CNT  = 3'd5;

  typedef struct packed {
    event_t              ev;
    logic [ValueW-1:0]   value;
    logic                is_start;
    logic                last;
  } result_t;

endpackage

// File: hw/rtl/app_packet_parser_unit.sv
// Byte-serial packet parser. One byte is taken per cycle with in_tuser marking the
// first byte of a packet, and the byte is decoded in the same cycle it is taken.
// Results go into a four-entry output queue; one byte yields at most two results
// (the last name byte of a control packet also yields control done). in_tready
// stays high while the queue has room for two results, so with a free-running
// sink the block sustains one byte per clock; a stalled sink holds in_tready low
// once three results are waiting. Results are registered in the queue before they
// reach the output. Configuration writes take effect at once and are always ready.
module app_packet_parser_unit #(
  parameter int SIZE_BITS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [app_pp_pkg::ByteW-1:0]   in_tdata,   // byte_in
  input  logic [0:0]                     in_tuser,   // first
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [app_pp_pkg::ValueW-1:0]  out_tdata,  // value
  output logic [3:0]                     out_tuser,  // event_res[2:0], is_start
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [app_pp_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [app_pp_pkg::CfgDataW-1:0] cfg_data
);
  import app_pp_pkg::*;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_LEN_HI  = 3'd1;
  localparam logic [2:0] PH_LEN_LO  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_TYPE    = 3'd4;
  localparam logic [2:0] PH_PLEN    = 3'd5;
  localparam logic [2:0] PH_PVAL    = 3'd6;

  // configuration
  logic [ByteW-1:0]     data_code_r, start_code_r, end_code_r;
  logic [ByteW-1:0]     size_type_r, name_type_r;
  logic [ParamCntW-1:0] param_cnt_r;

  // parser state
  logic [2:0]           phase_r, phase_nxt;
  logic [LenW-1:0]      bytes_left_r, bytes_left_nxt;
  logic [ParamCntW-1:0] params_left_r, params_left_nxt;
  logic                 is_name_r, is_name_nxt;
  logic [SIZE_BITS-1:0] acc_r, acc_nxt;
  logic                 start_r, start_nxt;
  logic [ByteW-1:0]     len_hi_r, len_hi_nxt;

  // output queue
  result_t              q_r [QDepth];
  logic [QPtrW-1:0]     wr_ptr_r, rd_ptr_r, wr_ptr_p1;
  logic [CntW-1:0]      cnt_r, cnt_nxt;

  logic                 in_acc, out_acc;
  logic [ByteW-1:0]     b;
  logic [1:0]           push_n;
  result_t              res0, res1, done_res;
  logic [ParamCntW-1:0] pl_dec;
  logic [LenW-1:0]      bl_dec;

  assign b         = in_tdata;
  assign in_tready = (cnt_r <= CntW'(QDepth - 2));
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign wr_ptr_p1 = wr_ptr_r + QPtrW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_code_r  <= 8'd1;
      start_code_r <= 8'd2;
      end_code_r   <= 8'd3;
      size_type_r  <= 8'd0;
      name_type_r  <= 8'd1;
      param_cnt_r  <= 4'd2;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DATA_CODE:  data_code_r  <= cfg_data;
        CFG_START_CODE: start_code_r <= cfg_data;
        CFG_END_CODE:   end_code_r   <= cfg_data;
        CFG_SIZE_TYPE:  size_type_r  <= cfg_data;
        CFG_NAME_TYPE:  name_type_r  <= cfg_data;
        CFG_PARAM_CNT:  param_cnt_r  <= cfg_data[ParamCntW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    params_left_nxt = params_left_r;
    is_name_nxt     = is_name_r;
    acc_nxt         = acc_r;
    start_nxt       = start_r;
    len_hi_nxt      = len_hi_r;
    res0            = '0;
    res1            = '0;
    done_res        = '0;
    push_n          = 2'd0;
    pl_dec          = params_left_r - ParamCntW'(1);
    bl_dec          = bytes_left_r - LenW'(1);
    if (in_acc) begin
      if (in_tuser[0]) begin
        acc_nxt        = '0;
        bytes_left_nxt = '0;
        is_name_nxt    = 1'b0;
        priority if (b == data_code_r) begin
          phase_nxt = PH_LEN_HI;
        end else if (b == start_code_r || b == end_code_r) begin
          start_nxt       = (b == start_code_r);
          params_left_nxt = param_cnt_r;
          if (param_cnt_r == '0) begin
            res0     = '{ev: EV_DONE, value: '0, is_start: (b == start_code_r), last: 1'b0};
            push_n   = 2'd1;
            phase_nxt = PH_IDLE;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end else begin
          res0      = '{ev: EV_BAD_CTRL, value: ValueW'(b), is_start: 1'b0, last: 1'b0};
          push_n    = 2'd1;
          phase_nxt = PH_IDLE;
        end
      end else begin
        unique case (phase_r)
          PH_LEN_HI: begin
            len_hi_nxt = b;
            phase_nxt  = PH_LEN_LO;
          end
          PH_LEN_LO: begin
            bytes_left_nxt = {len_hi_r, b};
            res0      = '{ev: EV_LENGTH, value: ValueW'({len_hi_r, b}), is_start: 1'b0,
                         last: 1'b0};
            push_n    = 2'd1;
            phase_nxt = ({len_hi_r, b} == '0) ? PH_IDLE : PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            res0 = '{ev: EV_PAYLOAD, value: ValueW'(b), is_start: 1'b0,
                     last: (bytes_left_r == LenW'(1))};
            push_n         = 2'd1;
            bytes_left_nxt = bl_dec;
            if (bl_dec == '0) phase_nxt = PH_IDLE;
          end
          PH_TYPE: begin
            priority if (b == size_type_r) begin
              is_name_nxt = 1'b0;
              phase_nxt   = PH_PLEN;
            end else if (b == name_type_r) begin
              is_name_nxt = 1'b1;
              phase_nxt   = PH_PLEN;
            end else begin
              res0      = '{ev: EV_BAD_TYPE, value: ValueW'(b), is_start: 1'b0, last: 1'b0};
              push_n    = 2'd1;
              phase_nxt = PH_IDLE;
            end
          end
          PH_PLEN: begin
            bytes_left_nxt = LenW'(b);
            if (!is_name_r) acc_nxt = '0;
            if (b == '0) begin
              params_left_nxt = pl_dec;
              if (pl_dec == '0) begin
                res0      = '{ev: EV_DONE, value: ValueW'(acc_nxt), is_start: start_r,
                             last: 1'b0};
                push_n    = 2'd1;
                phase_nxt = PH_IDLE;
              end else begin
                phase_nxt = PH_TYPE;
              end
            end else begin
              phase_nxt = PH_PVAL;
            end
          end
          PH_PVAL: begin
            if (is_name_r) begin
              res0 = '{ev: EV_NAME, value: ValueW'(b), is_start: 1'b0,
                       last: (bytes_left_r == LenW'(1))};
              push_n = 2'd1;
            end else begin
              acc_nxt = SIZE_BITS'({acc_r, b});
            end
            bytes_left_nxt = bl_dec;
            if (bl_dec == '0) begin
              params_left_nxt = pl_dec;
              if (pl_dec == '0) begin
                done_res  = '{ev: EV_DONE, value: ValueW'(acc_nxt), is_start: start_r,
                             last: 1'b0};
                phase_nxt = PH_IDLE;
                if (is_name_r) begin
                  res1   = done_res;
                  push_n = 2'd2;
                end else begin
                  res0   = done_res;
                  push_n = 2'd1;
                end
              end else begin
                phase_nxt = PH_TYPE;
              end
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      bytes_left_r  <= '0;
      params_left_r <= '0;
      is_name_r     <= 1'b0;
      acc_r         <= '0;
      start_r       <= 1'b0;
      len_hi_r      <= '0;
    end else begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      params_left_r <= params_left_nxt;
      is_name_r     <= is_name_nxt;
      acc_r         <= acc_nxt;
      start_r       <= start_nxt;
      len_hi_r      <= len_hi_nxt;
    end
  end

  // output queue
  assign cnt_nxt = cnt_r + CntW'(push_n) - CntW'(out_acc);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= res0;
    if (push_n == 2'd2) q_r[wr_ptr_p1] <= res1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + QPtrW'(push_n);
      rd_ptr_r <= rd_ptr_r + QPtrW'(out_acc);
      cnt_r    <= cnt_nxt;
    end
  end

  assign out_tvalid = (cnt_r != '0);
  assign out_tdata  = q_r[rd_ptr_r].value;
  assign out_tuser  = {q_r[rd_ptr_r].is_start, q_r[rd_ptr_r].ev};
  assign out_tlast  = q_r[rd_ptr_r].last;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(QDepth))
    else $error("output queue overflow");

  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_tuser[0] && phase_r == PH_IDLE |=> cnt_r <= $past(cnt_r))
    else $error("result queued for an ignored byte");

  a_start_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[3] |-> out_tuser[2:0] == EV_DONE)
    else $error("start flag on a result other than control done");

  a_last_only_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[2:0] == EV_PAYLOAD || out_tuser[2:0] == EV_NAME)
    else $error("last mark on a result other than a payload or name byte");

endmodule
